FILE: hdl/kscd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kscd_pkg
// Shared types, constants and the US character maps for the scan code decoder.
// ----------------------------------------------------------------------------
package kscd_pkg;

  localparam logic [7:0] PREFIX_BYTE = 8'hE0;
  localparam logic [7:0] EXT_OFFSET  = 8'h80;
  localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT  = 7'h36;
  localparam logic [6:0] KEY_CTRL    = 7'h1D;
  localparam logic [6:0] KEY_ALT     = 7'h38;
  localparam logic [6:0] KEY_CAPS    = 7'h3A;
  localparam logic [7:0] MAP_LIMIT   = 8'h58;
  localparam logic [6:0] CASE_BIT    = 7'h20;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
  } mod_flags_t;

  typedef struct packed {
    logic [6:0] ascii_char;
    logic [7:0] key_index;
    logic       key_pressed;
  } key_res_t;

  function automatic logic [6:0] plain_char(input logic [6:0] key);
    logic [6:0] c;
    unique case (key)
      7'h02: c = 7'h31; 7'h03: c = 7'h32; 7'h04: c = 7'h33; 7'h05: c = 7'h34;
      7'h06: c = 7'h35; 7'h07: c = 7'h36; 7'h08: c = 7'h37; 7'h09: c = 7'h38;
      7'h0A: c = 7'h39; 7'h0B: c = 7'h30; 7'h0C: c = 7'h2D; 7'h0D: c = 7'h3D;
      7'h10: c = 7'h71; 7'h11: c = 7'h77; 7'h12: c = 7'h65; 7'h13: c = 7'h72;
      7'h14: c = 7'h74; 7'h15: c = 7'h79; 7'h16: c = 7'h75; 7'h17: c = 7'h69;
      7'h18: c = 7'h6F; 7'h19: c = 7'h70; 7'h1A: c = 7'h5B; 7'h1B: c = 7'h5D;
      7'h1E: c = 7'h61; 7'h1F: c = 7'h73; 7'h20: c = 7'h64; 7'h21: c = 7'h66;
      7'h22: c = 7'h67; 7'h23: c = 7'h68; 7'h24: c = 7'h6A; 7'h25: c = 7'h6B;
      7'h26: c = 7'h6C; 7'h27: c = 7'h3B; 7'h28: c = 7'h27; 7'h29: c = 7'h60;
      7'h2B: c = 7'h5C; 7'h2C: c = 7'h7A; 7'h2D: c = 7'h78; 7'h2E: c = 7'h63;
      7'h2F: c = 7'h76; 7'h30: c = 7'h62; 7'h31: c = 7'h6E; 7'h32: c = 7'h6D;
      7'h33: c = 7'h2C; 7'h34: c = 7'h2E; 7'h35: c = 7'h2F; 7'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] shifted_char(input logic [6:0] key);
    logic [6:0] c;
    unique case (key)
      7'h02: c = 7'h21; 7'h03: c = 7'h40; 7'h04: c = 7'h23; 7'h05: c = 7'h24;
      7'h06: c = 7'h25; 7'h07: c = 7'h5E; 7'h08: c = 7'h26; 7'h09: c = 7'h2A;
      7'h0A: c = 7'h28; 7'h0B: c = 7'h29; 7'h0C: c = 7'h5F; 7'h0D: c = 7'h2B;
      7'h10: c = 7'h51; 7'h11: c = 7'h57; 7'h12: c = 7'h45; 7'h13: c = 7'h52;
      7'h14: c = 7'h54; 7'h15: c = 7'h59; 7'h16: c = 7'h55; 7'h17: c = 7'h49;
      7'h18: c = 7'h4F; 7'h19: c = 7'h50; 7'h1A: c = 7'h7B; 7'h1B: c = 7'h7D;
      7'h1E: c = 7'h41; 7'h1F: c = 7'h53; 7'h20: c = 7'h44; 7'h21: c = 7'h46;
      7'h22: c = 7'h47; 7'h23: c = 7'h48; 7'h24: c = 7'h4A; 7'h25: c = 7'h4B;
      7'h26: c = 7'h4C; 7'h27: c = 7'h3A; 7'h28: c = 7'h22; 7'h29: c = 7'h7E;
      7'h2B: c = 7'h7C; 7'h2C: c = 7'h5A; 7'h2D: c = 7'h58; 7'h2E: c = 7'h43;
      7'h2F: c = 7'h56; 7'h30: c = 7'h42; 7'h31: c = 7'h4E; 7'h32: c = 7'h4D;
      7'h33: c = 7'h3C; 7'h34: c = 7'h3E; 7'h35: c = 7'h3F; 7'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/kscd_keymap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kscd_keymap
// Maps a key number to ASCII through the plain or shifted table, caps applied.
// ----------------------------------------------------------------------------
module kscd_keymap (
  input  logic [7:0] key_i,
  input  logic       shift_i,
  input  logic       caps_i,
  output logic [6:0] ascii_o
);

  logic [6:0] raw_char;
  logic       is_letter;

  always_comb begin
    if (key_i < kscd_pkg::MAP_LIMIT) begin
      raw_char = shift_i ? kscd_pkg::shifted_char(key_i[6:0])
                         : kscd_pkg::plain_char(key_i[6:0]);
    end else begin
      raw_char = 7'h00;
    end
  end

  assign is_letter = ((raw_char >= 7'h61) && (raw_char <= 7'h7A)) ||
                     ((raw_char >= 7'h41) && (raw_char <= 7'h5A));

  assign ascii_o = (caps_i && is_letter) ? (raw_char ^ kscd_pkg::CASE_BIT) : raw_char;

endmodule

FILE: hdl/kscd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kscd_decode
// Next-state logic for prefix and modifier flags, and the result of one byte.
// ----------------------------------------------------------------------------
module kscd_decode (
  input  logic                   [7:0] scan_byte_i,
  input  logic                         prefix_i,
  input  kscd_pkg::mod_flags_t         flags_i,
  output logic                         prefix_o,
  output kscd_pkg::mod_flags_t         flags_o,
  output kscd_pkg::key_res_t           res_o
);

  logic       is_prefix;
  logic       pressed;
  logic [7:0] key;
  logic [6:0] ascii;

  assign is_prefix = (scan_byte_i == kscd_pkg::PREFIX_BYTE);
  assign pressed   = ~scan_byte_i[7];
  assign key       = {1'b0, scan_byte_i[6:0]} | (prefix_i ? kscd_pkg::EXT_OFFSET : 8'h00);

  always_comb begin
    flags_o = flags_i;
    if (!is_prefix) begin
      priority if ((key == {1'b0, kscd_pkg::KEY_LSHIFT}) ||
                   (key == {1'b0, kscd_pkg::KEY_RSHIFT})) begin
        flags_o.shift = pressed;
      end else if (key == {1'b0, kscd_pkg::KEY_CTRL}) begin
        flags_o.ctrl = pressed;
      end else if (key == {1'b0, kscd_pkg::KEY_ALT}) begin
        flags_o.alt = pressed;
      end else if ((key == {1'b0, kscd_pkg::KEY_CAPS}) && pressed) begin
        flags_o.caps = ~flags_i.caps;
      end else begin
        flags_o = flags_i;
      end
    end
  end

  kscd_keymap u_keymap (
    .key_i   (key),
    .shift_i (flags_o.shift),
    .caps_i  (flags_o.caps),
    .ascii_o (ascii)
  );

  assign prefix_o = is_prefix;

  always_comb begin
    if (is_prefix) begin
      res_o = '0;
    end else begin
      res_o.ascii_char  = pressed ? ascii : 7'h00;
      res_o.key_index   = key;
      res_o.key_pressed = pressed;
    end
  end

endmodule

FILE: hdl/keyboard_scan_code_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_scan_code_decoder_unit
// Scan code set 1 byte stream to US ASCII with shift, ctrl, alt and caps state.
// ----------------------------------------------------------------------------
// The result is valid on the output register in the cycle after the input transaction.
// Throughput: 1 byte per cycle while out_ready_i drains the output; the single output register sets this figure.
// Input is taken whenever the output register is empty or being drained.
// Reset: asynchronous, clears prefix, modifier flags and output valid.
module keyboard_scan_code_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] ascii_char_o,
  output logic [7:0] key_index_o,
  output logic       key_pressed_o,
  output logic       shift_down_o,
  output logic       ctrl_down_o,
  output logic       alt_down_o,
  output logic       caps_active_o
);

  logic                 prefix_q, prefix_d;
  kscd_pkg::mod_flags_t flags_q, flags_d;
  kscd_pkg::key_res_t   res_q, res_d;
  logic                 out_valid_q;
  logic                 in_fire;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  kscd_decode u_decode (
    .scan_byte_i (scan_byte_i),
    .prefix_i    (prefix_q),
    .flags_i     (flags_q),
    .prefix_o    (prefix_d),
    .flags_o     (flags_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q    <= 1'b0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        prefix_q <= prefix_d;
        flags_q  <= flags_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ascii_char_o  = res_q.ascii_char;
  assign key_index_o   = res_q.key_index;
  assign key_pressed_o = res_q.key_pressed;
  assign shift_down_o  = flags_q.shift;
  assign ctrl_down_o   = flags_q.ctrl;
  assign alt_down_o    = flags_q.alt;
  assign caps_active_o = flags_q.caps;

  a_char_needs_make: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (ascii_char_o != 7'h00)) |-> (key_pressed_o && !key_index_o[7]))
    else $error("character on a break, prefix or extended transaction");

  a_prefix_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (scan_byte_i == kscd_pkg::PREFIX_BYTE)) |=> prefix_q)
    else $error("prefix not held after prefix transaction");

  a_caps_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !prefix_q && (scan_byte_i == {1'b0, kscd_pkg::KEY_CAPS}))
      |=> (flags_q.caps != $past(flags_q.caps)))
    else $error("caps lock did not toggle");

endmodule
